### src/plw_pkg.sv
package plw_pkg;

    localparam int PATH_DEPTH = 256;
    localparam int ADDR_W     = $clog2(PATH_DEPTH);
    localparam int LEN_W      = $clog2(PATH_DEPTH + 1);
    localparam int COORD_W    = 32;
    localparam int WORD_W     = 2 * COORD_W;
    localparam int DIST_W     = 2 * COORD_W + 1;
    localparam int LOOK_W     = 4;
    localparam int NEAR_W     = 8;
    localparam int SUM_W      = ADDR_W + LOOK_W + 1;

    localparam logic [LOOK_W-1:0] LOOKAHEAD_RESET = LOOK_W'(3);

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic [NEAR_W-1:0]         nearest_index;
        logic [1:0]                status;
    } t_out_item;

    // Tag that travels with each waypoint read during a scan.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic [ADDR_W-1:0] idx;
    } t_scan_tag;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] best_idx;
    } t_dist_status;

endpackage

### src/plw_ram.sv
module plw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/plw_dist_unit.sv
module plw_dist_unit import plw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_scan_tag                 i_tag,
    input  logic [WORD_W-1:0]         i_word,
    input  logic signed [COORD_W-1:0] i_qry_x,
    input  logic signed [COORD_W-1:0] i_qry_y,
    output t_dist_status              o_status
);

    // Stage 1: absolute differences. Stage 2: squares. Stage 3: sum.
    // Stage 4: compare against the running best.
    t_scan_tag              r_tag1, r_tag2, r_tag3;
    logic [COORD_W-1:0]     r_dx, r_dy;
    logic [2*COORD_W-1:0]   r_sx, r_sy;
    logic [DIST_W-1:0]      r_sum;
    logic [DIST_W-1:0]      r_best;
    logic [ADDR_W-1:0]      r_best_idx;

    logic signed [COORD_W:0] diff_x, diff_y;
    logic signed [COORD_W:0] abs_x, abs_y;

    always_comb begin
        diff_x = {i_word[WORD_W-1], i_word[WORD_W-1:COORD_W]} - {i_qry_x[COORD_W-1], i_qry_x};
        diff_y = {i_word[COORD_W-1], i_word[COORD_W-1:0]} - {i_qry_y[COORD_W-1], i_qry_y};
        abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
        abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else begin
            r_tag1.valid <= i_tag.valid;
            r_tag2.valid <= r_tag1.valid;
            r_tag3.valid <= r_tag2.valid;
        end
        r_tag1.first <= i_tag.first;
        r_tag1.idx   <= i_tag.idx;
        r_tag2.first <= r_tag1.first;
        r_tag2.idx   <= r_tag1.idx;
        r_tag3.first <= r_tag2.first;
        r_tag3.idx   <= r_tag2.idx;
        r_dx  <= abs_x[COORD_W-1:0];
        r_dy  <= abs_y[COORD_W-1:0];
        r_sx  <= r_dx * r_dx;
        r_sy  <= r_dy * r_dy;
        r_sum <= {1'b0, r_sx} + {1'b0, r_sy};
        // Strict less-than keeps the lowest index on a tie.
        if (r_tag3.valid && (r_tag3.first || (r_sum < r_best))) begin
            r_best     <= r_sum;
            r_best_idx <= r_tag3.idx;
        end
    end

    assign o_status.busy     = r_tag1.valid | r_tag2.valid | r_tag3.valid;
    assign o_status.best_idx = r_best_idx;

endmodule

### src/path_lookahead_waypoint.sv
// Channel   Direction  Signals                          Accepted when
// item in   input      start, busy, i_item              start high and busy low
// result    output     o_result_valid, o_result         every cycle o_result_valid is high
// config    input      i_cfg_valid, o_cfg_ready, data   i_cfg_valid and o_cfg_ready high
//
// A clear, an append, an unused mode or a query on an empty path gives its result in the
// cycle after it is accepted, and busy stays low, so such items can follow each other
// in every cycle.
// A query on a non-empty path keeps busy high until its result is shown, in the cycle in
// which busy falls: the single RAM port reads one waypoint per cycle, the distance
// pipeline then drains, and the target is read from the RAM in the fetch state.
// Reset is synchronous and active low; it empties the path and sets lookahead to three.
// The receiver cannot stall: each result is shown for exactly one cycle.
module path_lookahead_waypoint import plw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_result_valid,
    output t_out_item         o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LOOK_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_FETCH = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [LOOK_W-1:0]   r_look;
    logic [ADDR_W-1:0]   r_scan_idx, n_scan_idx;
    logic [ADDR_W-1:0]   r_pick, n_pick;
    logic                r_rd_vld;
    logic                r_rd_first;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic signed [COORD_W-1:0] r_qry_x, r_qry_y;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out, n_out;

    logic                accept;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                scan_rd;
    logic [ADDR_W-1:0]   last_idx;
    logic [SUM_W-1:0]    ahead;
    logic [ADDR_W+NEAR_W-1:0] near_ext;
    t_scan_tag           rd_tag;
    t_dist_status        dist_st;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign last_idx    = ADDR_W'(r_len - LEN_W'(1));
    assign scan_rd     = (r_state == S_SCAN);

    // Writes happen only while idle and read data is used only during a query, so the RAM
    // never sees a write and a used read of the same entry in flight together.
    assign ram_we = accept && (i_item.mode == MODE_APPEND) && (r_len < LEN_W'(PATH_DEPTH));

    always_comb begin
        if (r_state == S_SCAN) begin
            ram_addr = r_scan_idx;
        end else if (r_state == S_FETCH) begin
            ram_addr = r_pick;
        end else begin
            ram_addr = r_len[ADDR_W-1:0];
        end
    end

    plw_ram #(
        .WIDTH(WORD_W),
        .DEPTH(PATH_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_item.pos_x, i_item.pos_y}),
        .o_rdata (ram_rdata)
    );

    assign rd_tag.valid = r_rd_vld;
    assign rd_tag.first = r_rd_first;
    assign rd_tag.idx   = r_rd_idx;

    plw_dist_unit u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (rd_tag),
        .i_word   (ram_rdata),
        .i_qry_x  (r_qry_x),
        .i_qry_y  (r_qry_y),
        .o_status (dist_st)
    );

    // The lookahead target, later clamped to the last waypoint of the path.
    assign ahead    = SUM_W'(dist_st.best_idx) + SUM_W'(r_look);
    assign near_ext = {{NEAR_W{1'b0}}, dist_st.best_idx};

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_scan_idx = r_scan_idx;
        n_pick     = r_pick;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    priority if (i_item.mode == MODE_CLEAR) begin
                        n_len = '0;
                    end else if (i_item.mode == MODE_APPEND) begin
                        if (r_len < LEN_W'(PATH_DEPTH)) begin
                            n_len = r_len + LEN_W'(1);
                        end else begin
                            n_out.status = STAT_FULL;
                        end
                    end else if (i_item.mode == MODE_QUERY) begin
                        if (r_len == '0) begin
                            n_out.status = STAT_EMPTY;
                        end else begin
                            n_out_vld  = 1'b0;
                            n_scan_idx = '0;
                            n_state    = S_SCAN;
                        end
                    end else begin
                        // The unused mode changes nothing and reports all zeros.
                        n_out.status = STAT_OK;
                    end
                end
            end
            S_SCAN: begin
                n_scan_idx = r_scan_idx + ADDR_W'(1);
                if (r_scan_idx == last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !dist_st.busy) begin
                    if (ahead < SUM_W'(r_len)) begin
                        n_pick = ahead[ADDR_W-1:0];
                    end else begin
                        n_pick = last_idx;
                    end
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_out_vld           = 1'b1;
                n_out.target_x      = ram_rdata[WORD_W-1:COORD_W];
                n_out.target_y      = ram_rdata[COORD_W-1:0];
                n_out.nearest_index = near_ext[NEAR_W-1:0];
                n_out.status        = STAT_OK;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_look    <= LOOKAHEAD_RESET;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_rd_vld  <= scan_rd;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_look <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
        r_pick     <= n_pick;
        r_out      <= n_out;
        r_rd_idx   <= r_scan_idx;
        r_rd_first <= (r_scan_idx == '0);
        if (accept) begin
            r_qry_x <= i_item.pos_x;
            r_qry_y <= i_item.pos_y;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

endmodule

### src/plw_checker.sv
module plw_checker import plw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input t_in_item          i_item,
    input logic              o_result_valid,
    input t_out_item         o_result,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [LOOK_W-1:0] i_cfg_data
);

    // A non-query item reports at once, with no target and no index.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.mode != MODE_QUERY)) |=>
        (o_result_valid && (o_result.target_x == '0) && (o_result.target_y == '0)
         && (o_result.nearest_index == '0)))
        else $error("non-query item did not report a zero result in the next cycle");

    // A query either reports an empty path at once or starts a scan.
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.mode == MODE_QUERY)) |=> (busy != o_result_valid))
        else $error("query neither started a scan nor reported an empty path");

    // An empty-path status carries no target.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == STAT_EMPTY)) |->
        ((o_result.target_x == '0) && (o_result.target_y == '0)))
        else $error("empty-path result carries a target");

    // The end of a scan produces an ok result.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_result_valid && (o_result.status == STAT_OK)))
        else $error("scan ended without an ok result");

    // Configuration is only taken while the block is idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !busy)
        else $error("configuration write taken during a query");

endmodule

bind path_lookahead_waypoint plw_checker u_plw_checker (.*);
